// ----- sv/ipfs_pkg.sv -----
// Shared types and constants of the IP fragment scheduler.
`default_nettype none

package ipfs_pkg;

   localparam int LEN_W   = 13;
   localparam int START_W = 12;
   localparam int OFFS_W  = 13;
   localparam int IDENT_W = 16;
   localparam int DELTA_W = OFFS_W - 3;
   localparam int CSR_W   = 16;
   localparam int ADDR_W  = 2;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_BYTES = 13'd4096;
   localparam logic [LEN_W-1:0] MIN_SIZE          = 13'd64;
   localparam logic [5:0]       LAST_PIECE_INDEX  = 6'd63;

   localparam logic [ADDR_W-1:0] REG_FRAGMENT_SIZE    = 2'd0;
   localparam logic [ADDR_W-1:0] REG_FRAGMENT_OVERLAP = 2'd1;
   localparam logic [ADDR_W-1:0] REG_OFFSET_BASE      = 2'd2;
   localparam logic [ADDR_W-1:0] REG_IDENT_SEED       = 2'd3;

   // One classified packet, ready to be cut into fragments.
   typedef struct packed {
      logic               bypass;
      logic [LEN_W-1:0]   length;
      logic [LEN_W-1:0]   size;
      logic [DELTA_W-1:0] delta;
      logic [OFFS_W-1:0]  base;
      logic [IDENT_W-1:0] ident;
   } cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   // One fragment descriptor.
   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
      logic [OFFS_W-1:0]  offset;
      logic               more;
      logic [IDENT_W-1:0] ident;
      logic               last;
   } piece_type;

endpackage

`default_nettype wire

// ----- sv/ipfs_front.sv -----
// Front end: configuration registers, request classification and the command queue.
`default_nettype none

module ipfs_front import ipfs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [LEN_W-1:0]   req_payload_length,
   output cmd_head_type            cmd_head,
   input  wire logic               cmd_pop
);

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   logic [LEN_W-1:0]   size_ff, size_in;
   logic [LEN_W-1:0]   overlap_ff, overlap_in;
   logic [OFFS_W-1:0]  base_ff, base_in;
   logic [IDENT_W-1:0] ident_ff, ident_in;

   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   cmd_type    queue_ff [2];

   logic             accept;
   logic             bypass;
   logic [LEN_W-1:0] len_sat;
   logic [LEN_W-1:0] size_eff;
   logic [LEN_W-1:0] overlap_eff;
   logic [LEN_W-1:0] advance;
   cmd_type          cmd_new;

   assign req_full = (cnt_ff == QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   // Classification of the incoming request.
   always_comb begin
      bypass      = (size_ff == '0);
      len_sat     = (req_payload_length > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES
                                                             : req_payload_length;
      size_eff    = (size_ff < MIN_SIZE) ? MIN_SIZE : size_ff;
      overlap_eff = (overlap_ff > size_eff) ? size_eff : overlap_ff;
      advance     = size_eff - overlap_eff;
      cmd_new.bypass = bypass;
      cmd_new.length = len_sat;
      cmd_new.size   = size_eff;
      cmd_new.delta  = advance[LEN_W-1:3];
      cmd_new.base   = base_ff;
      cmd_new.ident  = bypass ? ident_ff : ident_ff + 16'd1;
   end

   always_comb begin
      size_in    = size_ff;
      overlap_in = overlap_ff;
      base_in    = base_ff;
      ident_in   = ident_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_FRAGMENT_SIZE:    size_in    = csr_wdata[LEN_W-1:0];
            REG_FRAGMENT_OVERLAP: overlap_in = csr_wdata[LEN_W-1:0];
            REG_OFFSET_BASE:      base_in    = csr_wdata[OFFS_W-1:0];
            REG_IDENT_SEED:       ident_in   = csr_wdata[IDENT_W-1:0];
            default: ;
         endcase
      end else if (accept) begin
         ident_in = cmd_new.ident;
      end
   end

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!accept && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= '0;
         overlap_ff <= '0;
         base_ff    <= '0;
         ident_ff   <= '0;
         cnt_ff     <= '0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
      end else begin
         size_ff    <= size_in;
         overlap_ff <= overlap_in;
         base_ff    <= base_in;
         ident_ff   <= ident_in;
         cnt_ff     <= cnt_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_head.valid = (cnt_ff != 2'd0);
   assign cmd_head.cmd   = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/ipfs_back.sv -----
// Back end: fragment sequencer and the response queue.
`default_nettype none

module ipfs_back import ipfs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_head_type       cmd_head,
   output logic                    cmd_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output piece_type               rsp_head
);

   localparam logic       ST_IDLE     = 1'b0;
   localparam logic       ST_RUN      = 1'b1;
   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   logic               state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [LEN_W-1:0]   ptr_ff, ptr_in;
   logic [OFFS_W-1:0]  offs_ff, offs_in;
   logic [5:0]         count_ff, count_in;

   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   piece_type  queue_ff [2];

   logic        out_full;
   logic        emit;
   logic        more;
   logic        pop_out;
   logic [LEN_W:0] reach;
   piece_type   piece;

   assign out_full = (cnt_ff == QUEUE_DEPTH);
   assign emit     = (state_ff == ST_RUN) && !out_full;
   assign pop_out  = rsp_pop && !rsp_empty;

   always_comb begin
      reach = {1'b0, ptr_ff} + {1'b0, cmd_ff.size};
      more  = !cmd_ff.bypass && (reach < {1'b0, cmd_ff.length})
              && (count_ff != LAST_PIECE_INDEX);
      piece.start  = ptr_ff[START_W-1:0];
      piece.length = more ? cmd_ff.size : cmd_ff.length - ptr_ff;
      piece.offset = offs_ff;
      piece.more   = more;
      piece.ident  = cmd_ff.ident;
      piece.last   = !more;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ptr_in   = ptr_ff;
      offs_in  = offs_ff;
      count_in = count_ff;
      cmd_pop  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_head.valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head.cmd;
               ptr_in   = '0;
               offs_in  = cmd_head.cmd.base;
               count_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit) begin
               if (more) begin
                  ptr_in   = reach[LEN_W-1:0];
                  offs_in  = offs_ff + {{(OFFS_W-DELTA_W){1'b0}}, cmd_ff.delta};
                  count_in = count_ff + 6'd1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_ptr_in = emit ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_out ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (emit && !pop_out) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!emit && pop_out) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ptr_ff    <= '0;
         offs_ff   <= '0;
         count_ff  <= '0;
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         offs_ff   <= offs_in;
         count_ff  <= count_in;
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         queue_ff[wr_ptr_ff] <= piece;
      end
   end

   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_head  = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/ip_fragment_scheduler.sv -----
// Top level of the IP fragment scheduler.
`default_nettype none

// Each request carries the IP payload length of one packet; the block answers with the
// run of fragment descriptors for that packet, oldest first, each giving the byte start,
// the length, the 13-bit fragment offset field, the MF flag, the IP identification and a
// flag on the final descriptor of the packet. Lengths above 4096 bytes are saturated.
// A fragment size of zero passes the packet through as one descriptor with MF clear and
// leaves the identification counter alone; otherwise the counter advances once per
// packet, sizes below 64 are taken as 64, and the overlap is clamped to the size. At most
// 64 descriptors are produced, the last carrying every remaining byte. The back-end
// fragment sequencer produces one descriptor per cycle while the response queue has room
// and loads each packet from the command queue while idle, taking no new packet before
// the last is done. The front end takes a request in any cycle while its two-entry
// command queue has room, and a two-entry response queue lets the sequencer run ahead
// of a consumer that stalls. The user writes registers only while the block is idle,
// not enforced by the block; writing the identification seed loads the counter at once.

module ip_fragment_scheduler import ipfs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [LEN_W-1:0]   req_payload_length,
   output logic                    empty,
   input  wire logic               pop,
   output logic [START_W-1:0]      rsp_piece_start,
   output logic [LEN_W-1:0]        rsp_piece_length,
   output logic [OFFS_W-1:0]       rsp_offset_field,
   output logic                    rsp_more_fragments,
   output logic [IDENT_W-1:0]      rsp_ident,
   output logic                    rsp_last_piece
);

   cmd_head_type cmd_head;
   logic         cmd_pop;
   piece_type    rsp_head;

   // The front end holds the registers and the identification counter, and classifies
   // each request into a command before it enters the queue.
   ipfs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .req_push           (push),
      .req_full           (full),
      .req_payload_length (req_payload_length),
      .cmd_head           (cmd_head),
      .cmd_pop            (cmd_pop)
   );

   // The back end walks each command, one fragment per cycle while its response queue has room.
   ipfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_piece_start    = rsp_head.start;
   assign rsp_piece_length   = rsp_head.length;
   assign rsp_offset_field   = rsp_head.offset;
   assign rsp_more_fragments = rsp_head.more;
   assign rsp_ident          = rsp_head.ident;
   assign rsp_last_piece     = rsp_head.last;

endmodule

`default_nettype wire

// ----- tb/sv/ipfs_fragment_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the fragment descriptors of the scheduler and compares them.
module ipfs_fragment_checker import ipfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [ADDR_W-1:0]  csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic               push,
   input  logic               full,
   input  logic [LEN_W-1:0]   req_payload_length,
   input  logic               empty,
   input  logic               pop,
   input  logic [START_W-1:0] rsp_piece_start,
   input  logic [LEN_W-1:0]   rsp_piece_length,
   input  logic [OFFS_W-1:0]  rsp_offset_field,
   input  logic               rsp_more_fragments,
   input  logic [IDENT_W-1:0] rsp_ident,
   input  logic               rsp_last_piece,
   output int                 pieces_waiting,
   output int                 fault_count
);

   logic [LEN_W-1:0]   size_reg;
   logic [LEN_W-1:0]   overlap_reg;
   logic [OFFS_W-1:0]  base_reg;
   logic [IDENT_W-1:0] ident_count;
   piece_type          expected_pieces[$];

   initial begin
      pieces_waiting = 0;
      fault_count    = 0;
   end

   // Appends the descriptors that one packet of the given length is cut into.
   task automatic cut_packet(input logic [LEN_W-1:0] raw_len);
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  cut;
      logic [LEN_W-1:0]  lap;
      logic [LEN_W-1:0]  ptr;
      logic [OFFS_W-1:0] adv;
      logic [OFFS_W-1:0] offs;
      int                count;
      len = (raw_len > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : raw_len;
      if (size_reg == '0) begin
         expected_pieces.push_back(piece_type'{start: '0, length: len, offset: base_reg,
                                               more: 1'b0, ident: ident_count, last: 1'b1});
      end else begin
         cut   = (size_reg < MIN_SIZE) ? MIN_SIZE : size_reg;
         lap   = (overlap_reg > cut) ? cut : overlap_reg;
         adv   = (cut - lap) >> 3;
         ident_count = ident_count + 1'b1;
         ptr   = '0;
         offs  = base_reg;
         count = 0;
         while ((int'(ptr) + int'(cut)) < int'(len) && count < int'(LAST_PIECE_INDEX)) begin
            expected_pieces.push_back(piece_type'{start: ptr[START_W-1:0], length: cut,
                                                  offset: offs, more: 1'b1,
                                                  ident: ident_count, last: 1'b0});
            ptr   = ptr + cut;
            offs  = offs + adv;
            count = count + 1;
         end
         expected_pieces.push_back(piece_type'{start: ptr[START_W-1:0], length: len - ptr,
                                               offset: offs, more: 1'b0,
                                               ident: ident_count, last: 1'b1});
      end
   endtask

   task automatic log_fault(input string what, input piece_type want, input piece_type got);
      fault_count = fault_count + 1;
      if (fault_count <= 10) begin
         $display("%0t: %s: expected start %0d len %0d offs %0d mf %0b id %0d last %0b,",
                  $time, what, want.start, want.length, want.offset, want.more,
                  want.ident, want.last,
                  " got start %0d len %0d offs %0d mf %0b id %0d last %0b",
                  got.start, got.length, got.offset, got.more, got.ident, got.last);
      end
   endtask

   always @(posedge clock) begin
      piece_type got;
      piece_type want;
      if (reset) begin
         size_reg    = '0;
         overlap_reg = '0;
         base_reg    = '0;
         ident_count = '0;
         expected_pieces.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_FRAGMENT_SIZE:    size_reg    = csr_wdata[LEN_W-1:0];
               REG_FRAGMENT_OVERLAP: overlap_reg = csr_wdata[LEN_W-1:0];
               REG_OFFSET_BASE:      base_reg    = csr_wdata[OFFS_W-1:0];
               REG_IDENT_SEED:       ident_count = csr_wdata[IDENT_W-1:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            cut_packet(req_payload_length);
         end
         if (pop && !empty) begin
            got = piece_type'{start: rsp_piece_start, length: rsp_piece_length,
                              offset: rsp_offset_field, more: rsp_more_fragments,
                              ident: rsp_ident, last: rsp_last_piece};
            if (expected_pieces.size() == 0) begin
               log_fault("unexpected descriptor", '0, got);
            end else begin
               want = expected_pieces.pop_front();
               if (got !== want) begin
                  log_fault("descriptor mismatch", want, got);
               end
            end
         end
      end
      pieces_waiting <= expected_pieces.size();
   end

endmodule

// ----- tb/sv/tb_ip_fragment_scheduler.sv -----
`timescale 1ns / 1ps
// Testbench top of the IP fragment scheduler: stimulus, register writes and verdict.
module tb_ip_fragment_scheduler;
   import ipfs_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;
   logic               push = 1'b0;
   logic               full;
   logic [LEN_W-1:0]   req_payload_length = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [START_W-1:0] rsp_piece_start;
   logic [LEN_W-1:0]   rsp_piece_length;
   logic [OFFS_W-1:0]  rsp_offset_field;
   logic               rsp_more_fragments;
   logic [IDENT_W-1:0] rsp_ident;
   logic               rsp_last_piece;
   int                 pieces_waiting;
   int                 fault_count;

   // When set, the sender offers its requests back to back for the whole phase.
   logic               quiet_send = 1'b0;

   always #6 clock = ~clock;

   ip_fragment_scheduler u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .push               (push),
      .full               (full),
      .req_payload_length (req_payload_length),
      .empty              (empty),
      .pop                (pop),
      .rsp_piece_start    (rsp_piece_start),
      .rsp_piece_length   (rsp_piece_length),
      .rsp_offset_field   (rsp_offset_field),
      .rsp_more_fragments (rsp_more_fragments),
      .rsp_ident          (rsp_ident),
      .rsp_last_piece     (rsp_last_piece)
   );

   // The checker watches both channels and the register port beside the block.
   ipfs_fragment_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .push               (push),
      .full               (full),
      .req_payload_length (req_payload_length),
      .empty              (empty),
      .pop                (pop),
      .rsp_piece_start    (rsp_piece_start),
      .rsp_piece_length   (rsp_piece_length),
      .rsp_offset_field   (rsp_offset_field),
      .rsp_more_fragments (rsp_more_fragments),
      .rsp_ident          (rsp_ident),
      .rsp_last_piece     (rsp_last_piece),
      .pieces_waiting     (pieces_waiting),
      .fault_count        (fault_count)
   );

   // Offers one request after a random gap and returns at the edge that accepts it.
   // The push line is left high, so a following request with no gap keeps it asserted.
   task automatic send_packet(input logic [LEN_W-1:0] len);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_payload_length <= len;
      do @(posedge clock); while (full);
   endtask

   // Register writes take effect at the next edge; the caller lowers the enable afterwards.
   task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Stops offering requests and waits until every predicted descriptor has been taken.
   // Every request yields at least one descriptor, so an empty prediction store means
   // the block is idle and may be reconfigured.
   task automatic finish_phase();
      push <= 1'b0;
      do @(posedge clock); while (pieces_waiting != 0);
   endtask

   // Payload lengths are mostly legal sizes, with the extremes and the saturating
   // range above the maximum mixed in.
   function automatic logic [LEN_W-1:0] random_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return MAX_PAYLOAD_BYTES;
         2:       return LEN_W'($urandom_range(4097, 8191));
         3:       return LEN_W'($urandom_range(1, 128));
         default: return LEN_W'($urandom_range(0, 4096));
      endcase
   endfunction

   // Sender: directed phases first, then random phases with random register settings.
   initial begin
      int sent;
      int phase_len;
      logic [CSR_W-1:0] value;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fragmentation off after reset: whole packets pass through, the identification
      // counter stays put, and lengths above the maximum are saturated.
      send_packet(13'd0);
      send_packet(13'd1);
      send_packet(13'd4096);
      send_packet(13'd4097);
      send_packet(13'h1FFF);
      send_packet(13'h0AAA);
      send_packet(13'h1555);
      finish_phase();

      // Smallest legal size, the offset field wrapping past its top and the
      // identification counter wrapping from its maximum to zero.
      write_reg(REG_FRAGMENT_SIZE, 16'd64);
      write_reg(REG_FRAGMENT_OVERLAP, 16'd0);
      write_reg(REG_OFFSET_BASE, 16'd8190);
      write_reg(REG_IDENT_SEED, 16'hFFFF);
      csr_we <= 1'b0;
      send_packet(13'd4096);
      send_packet(13'd0);
      send_packet(13'd65);
      send_packet(13'd64);
      finish_phase();

      // A size below the minimum is taken as the minimum, and an overlap above the
      // size is clamped, so the offset field does not advance at all.
      write_reg(REG_FRAGMENT_SIZE, 16'd1);
      write_reg(REG_FRAGMENT_OVERLAP, 16'd4096);
      write_reg(REG_OFFSET_BASE, 16'd0);
      write_reg(REG_IDENT_SEED, 16'h8000);
      csr_we <= 1'b0;
      send_packet(13'd200);
      send_packet(13'h1FFF);
      send_packet(13'd1);
      finish_phase();

      // Largest size and largest base; the seed is left alone so the counter carries on.
      write_reg(REG_FRAGMENT_SIZE, 16'd4096);
      write_reg(REG_FRAGMENT_OVERLAP, 16'd8);
      write_reg(REG_OFFSET_BASE, 16'd8191);
      csr_we <= 1'b0;
      send_packet(13'd4096);
      send_packet(13'd4095);
      send_packet(13'd0);
      send_packet(13'h1FFF);
      finish_phase();

      // The overlap clamp works against the size after it has been raised to the minimum.
      write_reg(REG_FRAGMENT_SIZE, 16'd63);
      write_reg(REG_FRAGMENT_OVERLAP, 16'd100);
      write_reg(REG_OFFSET_BASE, 16'd100);
      write_reg(REG_IDENT_SEED, 16'h1234);
      csr_we <= 1'b0;
      send_packet(13'd3000);
      send_packet(13'd64);
      finish_phase();

      // Random phases. Sizes lean towards small values so that long runs of fragments
      // are common, while the extremes still come up regularly.
      while (sent < 450) begin
         case ($urandom_range(0, 7))
            0:       value = 16'd0;
            1:       value = CSR_W'($urandom_range(1, 63));
            2:       value = 16'd64;
            3:       value = 16'd4096;
            4, 5:    value = CSR_W'($urandom_range(64, 512));
            default: value = CSR_W'($urandom_range(65, 4096));
         endcase
         write_reg(REG_FRAGMENT_SIZE, value);
         case ($urandom_range(0, 3))
            0:       value = 16'd0;
            1:       value = 16'd4096;
            2:       value = CSR_W'($urandom_range(0, 64));
            default: value = CSR_W'($urandom_range(0, 4096));
         endcase
         write_reg(REG_FRAGMENT_OVERLAP, value);
         case ($urandom_range(0, 3))
            0:       value = 16'd0;
            1:       value = 16'd8191;
            default: value = CSR_W'($urandom_range(0, 8191));
         endcase
         write_reg(REG_OFFSET_BASE, value);
         // The seed is written only now and then, so the counter also runs on across phases.
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
               0:       value = 16'd0;
               1:       value = 16'hFFFF;
               default: value = CSR_W'($urandom_range(0, 65535));
            endcase
            write_reg(REG_IDENT_SEED, value);
         end
         csr_we <= 1'b0;
         quiet_send = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(10, 40);
         repeat (phase_len) begin
            send_packet(random_length());
            sent = sent + 1;
         end
         finish_phase();
      end

      // Allow for a full packet's worth of cycles in case a stray descriptor appears.
      repeat (70) @(posedge clock);
      if (fault_count == 0 && pieces_waiting == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver: takes descriptors after random gaps, sometimes with no gaps at all.
   // Twice it holds off for a long stretch; the first time it waits until the sender
   // is offering a request, so the queues inside the block fill up and the request
   // side is stalled.
   initial begin
      int   gap;
      int   taken;
      logic quiet_take;
      logic held;
      taken      = 0;
      quiet_take = 1'b0;
      held       = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 32 == 0) begin
            quiet_take = ($urandom_range(0, 3) == 0);
         end
         if (!held && taken >= 500 && push) begin
            gap  = 300;
            held = 1'b1;
         end else if (taken == 3000) begin
            gap = 300;
         end else begin
            gap = quiet_take ? 0 : $urandom_range(0, 4);
         end
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         taken = taken + 1;
      end
   end

   // Watchdog: a correct run finishes far inside this bound.
   initial begin
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
